/* sv/cdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared constants and types for the correspondence deviation check.
// ----------------------------------------------------------------------------
package cdc_pkg;

  localparam int FracBits   = 16;
  localparam int IndexWidth = 16;
  localparam int CoordWidth = 32;
  localparam int DevWidth   = 32;
  localparam int SqWidth    = 64;
  // Mapped coordinate: three floored products plus translation.
  localparam int MapWidth   = 2 * CoordWidth - FracBits + 3;
  localparam int DiffWidth  = MapWidth + 1;
  localparam int RootSteps  = DevWidth;

  localparam int NumRegs    = 7;
  localparam int CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_ROW0_FIRST = 3'd0,
    REG_ROW0_LAST  = 3'd1,
    REG_ROW1_FIRST = 3'd2,
    REG_ROW1_LAST  = 3'd3,
    REG_ROW2_FIRST = 3'd4,
    REG_ROW2_LAST  = 3'd5,
    REG_THRESHOLD  = 3'd6
  } cfg_reg_t;

  typedef logic [IndexWidth-1:0]        index_t;
  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic [DevWidth-1:0]          dev_t;

  // Sideband carried alongside the arithmetic in every stage.
  typedef struct packed {
    index_t query_index;
    index_t match_index;
  } tag_t;

  // Affine matrix, top three rows.
  typedef struct packed {
    coord_t [2:0][3:0] coef;  // [row][c0,c1,c2,t]
  } matrix_t;

endpackage
`default_nettype wire

/* sv/cdc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_in_if
// Correspondence input channel: valid, ready and one correspondence.
// ----------------------------------------------------------------------------
interface cdc_in_if;
  import cdc_pkg::*;
  logic   valid;
  logic   ready;
  index_t query_index;
  index_t match_index;
  coord_t model_x;
  coord_t model_y;
  coord_t model_z;
  coord_t scene_x;
  coord_t scene_y;
  coord_t scene_z;
  modport source (output valid, query_index, match_index, model_x, model_y, model_z,
                  scene_x, scene_y, scene_z, input ready);
  modport sink (input valid, query_index, match_index, model_x, model_y, model_z,
                scene_x, scene_y, scene_z, output ready);
endinterface
`default_nettype wire

/* sv/cdc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_out_if
// Result channel: valid, ready, indices, deviation and inlier flag.
// ----------------------------------------------------------------------------
interface cdc_out_if;
  import cdc_pkg::*;
  logic   valid;
  logic   ready;
  index_t out_query_index;
  index_t out_match_index;
  dev_t   deviation;
  logic   is_inlier;
  modport source (output valid, out_query_index, out_match_index, deviation, is_inlier,
                  input ready);
  modport sink (input valid, out_query_index, out_match_index, deviation, is_inlier,
                output ready);
endinterface
`default_nettype wire

/* sv/cdc_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface cdc_cfg_if;
  import cdc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CfgIdxWidth-1:0] index;
  logic [63:0]            data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/cdc_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_cfg_regs
// Configuration register file holding the matrix and the inlier threshold.
// ----------------------------------------------------------------------------
module cdc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  cdc_cfg_if.sink                          cfg,
  output cdc_pkg::matrix_t                 matrix,
  output cdc_pkg::dev_t                    threshold
);
  import cdc_pkg::*;

  logic [63:0] pair_r [6];
  dev_t        thr_r;
  localparam logic [63:0] One = 64'(1) << FracBits;

  assign cfg.ready = 1'b1;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r[0] <= One;
      pair_r[1] <= '0;
      pair_r[2] <= One << 32;
      pair_r[3] <= '0;
      pair_r[4] <= '0;
      pair_r[5] <= One;
      thr_r     <= DevWidth'(One);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROW0_FIRST: pair_r[0] <= cfg.data;
        REG_ROW0_LAST:  pair_r[1] <= cfg.data;
        REG_ROW1_FIRST: pair_r[2] <= cfg.data;
        REG_ROW1_LAST:  pair_r[3] <= cfg.data;
        REG_ROW2_FIRST: pair_r[4] <= cfg.data;
        REG_ROW2_LAST:  pair_r[5] <= cfg.data;
        REG_THRESHOLD:  thr_r     <= cfg.data[DevWidth-1:0];
        default: ;
      endcase
    end
  end

  // Unpack pairs into coefficients.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      matrix.coef[r][0] = pair_r[2*r][31:0];
      matrix.coef[r][1] = pair_r[2*r][63:32];
      matrix.coef[r][2] = pair_r[2*r+1][31:0];
      matrix.coef[r][3] = pair_r[2*r+1][63:32];
    end
  end
  assign threshold = thr_r;

endmodule
`default_nettype wire

/* sv/cdc_transform.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_transform
// Four-stage affine map and squared distance: products, differences,
// squares and the saturated sum.
// Each stage advances when its output is empty or moving on.
// ----------------------------------------------------------------------------
module cdc_transform (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  cdc_in_if.sink                      in,
  input  wire cdc_pkg::matrix_t       matrix,
  output logic                        sq_valid,
  input  wire logic                   sq_ready,
  output cdc_pkg::tag_t               sq_tag,
  output logic [cdc_pkg::SqWidth-1:0] sq_sum
);
  import cdc_pkg::*;

  localparam int ProdWidth = 2 * CoordWidth;
  localparam int FlWidth   = ProdWidth - FracBits;
  localparam int MagWidth  = SqWidth / 2;

  // Stage 1: nine products, floored.
  logic                             v1_r;
  tag_t                             tag1_r;
  logic signed [FlWidth-1:0]        fl1_r [3][3];
  coord_t                           scene1_r [3];
  coord_t                           trans1_r [3];
  // Stage 2: differences.
  logic                             v2_r;
  tag_t                             tag2_r;
  logic signed [DiffWidth-1:0]      diff2_r [3];
  // Stage 3: squares.
  logic                             v3_r;
  tag_t                             tag3_r;
  logic [SqWidth-1:0]               sqr3_r [3];
  logic                             big3_r;
  // Stage 4: saturated sum.
  logic                             v4_r;
  tag_t                             tag4_r;
  logic [SqWidth-1:0]               sum4_r;

  logic en1, en2, en3, en4;
  assign en4 = !v4_r || sq_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in.ready = en1;

  coord_t mpt [3];
  coord_t spt [3];
  assign mpt[0] = in.model_x;
  assign mpt[1] = in.model_y;
  assign mpt[2] = in.model_z;
  assign spt[0] = in.scene_x;
  assign spt[1] = in.scene_y;
  assign spt[2] = in.scene_z;

  // Floor shift of an exact product is an arithmetic shift.
  always_ff @(posedge clk) begin
    if (en1) begin
      tag1_r <= '{query_index: in.query_index, match_index: in.match_index};
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          fl1_r[r][c] <= FlWidth'((ProdWidth'(matrix.coef[r][c]) * ProdWidth'(mpt[c]))
                                  >>> FracBits);
        end
        scene1_r[r] <= spt[r];
        trans1_r[r] <= matrix.coef[r][3];
      end
    end
  end

  // Sum of floored products and translation, subtracted from the scene point.
  always_ff @(posedge clk) begin
    if (en2) begin
      tag2_r <= tag1_r;
      for (int r = 0; r < 3; r++) begin
        diff2_r[r] <= DiffWidth'(scene1_r[r]) - DiffWidth'(fl1_r[r][0])
                    - DiffWidth'(fl1_r[r][1]) - DiffWidth'(fl1_r[r][2])
                    - DiffWidth'(trans1_r[r]);
      end
    end
  end

  // Square of each magnitude; a magnitude of 2^32 or more saturates.
  logic [DiffWidth-1:0] mag [3];
  logic                 over [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag[r]  = diff2_r[r][DiffWidth-1] ? (~diff2_r[r] + 1'b1) : diff2_r[r];
      over[r] = |mag[r][DiffWidth-1:MagWidth];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      tag3_r <= tag2_r;
      big3_r <= over[0] || over[1] || over[2];
      for (int r = 0; r < 3; r++) begin
        sqr3_r[r] <= SqWidth'(mag[r][MagWidth-1:0]) * SqWidth'(mag[r][MagWidth-1:0]);
      end
    end
  end

  // Saturating three-way sum.
  logic [SqWidth+1:0] wide_sum;
  assign wide_sum = (SqWidth+2)'(sqr3_r[0]) + (SqWidth+2)'(sqr3_r[1])
                  + (SqWidth+2)'(sqr3_r[2]);

  always_ff @(posedge clk) begin
    if (en4) begin
      tag4_r <= tag3_r;
      sum4_r <= (big3_r || (|wide_sum[SqWidth+1:SqWidth])) ? '1
              : wide_sum[SqWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  assign sq_valid = v4_r;
  assign sq_tag   = tag4_r;
  assign sq_sum   = sum4_r;

endmodule
`default_nettype wire

/* sv/cdc_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_isqrt
// Pipelined integer square root, two result bits per stage, then the
// threshold compare into the output register.
// ----------------------------------------------------------------------------
module cdc_isqrt (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   sq_valid,
  output logic                        sq_ready,
  input  wire cdc_pkg::tag_t          sq_tag,
  input  wire [cdc_pkg::SqWidth-1:0]  sq_sum,
  input  wire cdc_pkg::dev_t          threshold,
  cdc_out_if.source                   out
);
  import cdc_pkg::*;

  localparam int BitsPerStage = 2;
  localparam int NumStages    = RootSteps / BitsPerStage;
  localparam int RemWidth     = DevWidth + 2;

  logic               v_r    [NumStages];
  tag_t               tag_r  [NumStages];
  logic [SqWidth-1:0] rad_r  [NumStages];  // remaining radicand bits, shifted up
  logic [RemWidth-1:0] rem_r [NumStages];
  dev_t               root_r [NumStages];
  logic               en     [NumStages];

  logic v_out_r;
  logic en_out;
  assign en_out = !v_out_r || out.ready;

  always_comb begin
    en[NumStages-1] = !v_r[NumStages-1] || en_out;
    for (int s = NumStages - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end
  assign sq_ready = en[0];

  // Restoring digit recurrence, two digits per stage.
  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic [SqWidth-1:0]  rad_in;
    logic [RemWidth-1:0] rem_in;
    dev_t                root_in;
    tag_t                tag_in;
    logic                v_in;
    logic [SqWidth-1:0]  rad_a;
    logic [RemWidth-1:0] rem_a, rem_b, trial;
    dev_t                root_a, root_b;

    if (s == 0) begin : g_first
      assign rad_in  = sq_sum;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = sq_tag;
      assign v_in    = sq_valid;
    end else begin : g_next
      assign rad_in  = rad_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign tag_in  = tag_r[s-1];
      assign v_in    = v_r[s-1];
    end

    always_comb begin
      rad_a  = rad_in;
      rem_a  = rem_in;
      root_a = root_in;
      for (int k = 0; k < BitsPerStage; k++) begin
        rem_b  = {rem_a[RemWidth-3:0], rad_a[SqWidth-1:SqWidth-2]};
        rad_a  = rad_a << 2;
        trial  = {root_a, 2'b01};
        if (rem_b >= trial) begin
          rem_a  = rem_b - trial;
          root_b = {root_a[DevWidth-2:0], 1'b1};
        end else begin
          rem_a  = rem_b;
          root_b = {root_a[DevWidth-2:0], 1'b0};
        end
        root_a = root_b;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        tag_r[s]  <= tag_in;
        rad_r[s]  <= rad_a;
        rem_r[s]  <= rem_a;
        root_r[s] <= root_a;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= v_in;
      end
    end
  end

  // Output register with inlier flag.
  tag_t tag_out_r;
  dev_t dev_out_r;
  logic inl_out_r;
  always_ff @(posedge clk) begin
    if (en_out) begin
      tag_out_r <= tag_r[NumStages-1];
      dev_out_r <= root_r[NumStages-1];
      inl_out_r <= root_r[NumStages-1] <= threshold;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out_r <= 1'b0;
    end else if (en_out) begin
      v_out_r <= v_r[NumStages-1];
    end
  end

  assign out.valid           = v_out_r;
  assign out.out_query_index = tag_out_r.query_index;
  assign out.out_match_index = tag_out_r.match_index;
  assign out.deviation       = dev_out_r;
  assign out.is_inlier       = inl_out_r;

endmodule
`default_nettype wire

/* sv/correspondence_deviation_check_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// correspondence_deviation_check_core
// Maps a model point through an affine matrix and reports its distance to
// the matched scene point, with an inlier flag.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  in       sink       indices, model point, scene point
//  out      source     indices, deviation, inlier flag
//  cfg      sink       register index and 64-bit write data
//
// One beat is accepted each cycle while the output does not stall; a beat
// passes four transform stages, sixteen root stages and one output register.
// The depth is set by the square root, two result bits per stage.
// Synchronous active-low reset clears valid bits and loads the identity matrix.
// A stall at the output backs up stage by stage; empty stages still fill.
// ----------------------------------------------------------------------------
module correspondence_deviation_check_core (
  input  wire logic clk,
  input  wire logic rst_n,
  cdc_in_if.sink    in,
  cdc_out_if.source out,
  cdc_cfg_if.sink   cfg
);
  import cdc_pkg::*;

  matrix_t            matrix;
  dev_t               threshold;
  logic               sq_valid;
  logic               sq_ready;
  tag_t               sq_tag;
  logic [SqWidth-1:0] sq_sum;

  cdc_cfg_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .matrix    (matrix),
    .threshold (threshold)
  );

  cdc_transform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .in       (in),
    .matrix   (matrix),
    .sq_valid (sq_valid),
    .sq_ready (sq_ready),
    .sq_tag   (sq_tag),
    .sq_sum   (sq_sum)
  );

  cdc_isqrt u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .sq_valid  (sq_valid),
    .sq_ready  (sq_ready),
    .sq_tag    (sq_tag),
    .sq_sum    (sq_sum),
    .threshold (threshold),
    .out       (out)
  );

`ifndef SYNTHESIS
  // A zero deviation is flagged as an inlier: no threshold lies below zero.
  a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid && out.deviation == '0 |-> out.is_inlier)
    else $error("zero deviation not flagged as inlier");

  // A result held by the sink keeps its deviation.
  a_hold_dev: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid && !out.ready |=> out.valid && $stable(out.deviation))
    else $error("deviation changed while stalled");

  // A stalled transform output holds its squared distance.
  a_hold_sq: assert property (@(posedge clk) disable iff (!rst_n)
    sq_valid && !sq_ready |=> sq_valid && $stable(sq_sum))
    else $error("squared distance changed while stalled");
`endif

endmodule
`default_nettype wire

/* tb/sv/cdc_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_result_checker
// Watches the configuration, input and result channels of the deviation
// check. Every accepted input beat is mapped through a local copy of the
// affine matrix to give the expected deviation and inlier flag. Every
// accepted result beat is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module cdc_result_checker (
  input  logic clk,
  input  logic rst_n,
  cdc_in_if    mon_in,
  cdc_out_if   mon_out,
  cdc_cfg_if   mon_cfg,
  output int   fail_count,
  output int   pending
);
  import cdc_pkg::*;

  typedef struct {
    index_t     query_index;
    index_t     match_index;
    dev_t       deviation;
    logic       is_inlier;
  } deviation_result_t;

  logic [63:0]       coef_pair [6];
  dev_t              threshold;
  deviation_result_t expected_results [$];

  // Floored product of a coefficient and a coordinate.
  function automatic longint scaled_product(input coord_t c, input coord_t v);
    longint p;
    p = longint'(c) * longint'(v);
    return p >>> FracBits;
  endfunction

  // One mapped coordinate: three floored products plus the translation.
  function automatic longint mapped_coord(input int row, input coord_t x,
                                          input coord_t y, input coord_t z);
    coord_t c0, c1, c2, t;
    c0 = coef_pair[2*row][31:0];
    c1 = coef_pair[2*row][63:32];
    c2 = coef_pair[2*row+1][31:0];
    t  = coef_pair[2*row+1][63:32];
    return scaled_product(c0, x) + scaled_product(c1, y) + scaled_product(c2, z)
           + longint'(t);
  endfunction

  // Square of a difference, saturated once the magnitude reaches 2^32.
  function automatic logic [63:0] diff_square(input longint d);
    logic [63:0] m;
    m = (d < 0) ? -d : d;
    if (m[63:32] != 0) return '1;
    return m * m;
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Bitwise integer square root, floored.
  function automatic dev_t root_floor(input logic [63:0] v);
    logic [63:0] res, bitpos;
    res = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= res + bitpos) begin
        v   = v - (res + bitpos);
        res = (res >> 1) + bitpos;
      end else begin
        res = res >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return res[31:0];
  endfunction

  function automatic dev_t point_deviation(input coord_t mx, input coord_t my,
                                           input coord_t mz, input coord_t sx,
                                           input coord_t sy, input coord_t sz);
    longint      dx, dy, dz;
    logic [63:0] sq;
    dx = longint'(sx) - mapped_coord(0, mx, my, mz);
    dy = longint'(sy) - mapped_coord(1, mx, my, mz);
    dz = longint'(sz) - mapped_coord(2, mx, my, mz);
    sq = add_sat(add_sat(diff_square(dx), diff_square(dy)), diff_square(dz));
    return root_floor(sq);
  endfunction

  // Track configuration, predict on input beats, compare on result beats.
  always @(posedge clk) begin
    deviation_result_t want;
    if (!rst_n) begin
      coef_pair[0] = 64'd1 << FracBits;
      coef_pair[1] = 0;
      coef_pair[2] = 64'd1 << (FracBits + 32);
      coef_pair[3] = 0;
      coef_pair[4] = 0;
      coef_pair[5] = 64'd1 << FracBits;
      threshold    = 32'd1 << FracBits;
      expected_results.delete();
      fail_count   = 0;
    end else begin
      if (mon_cfg.valid && mon_cfg.ready) begin
        if (mon_cfg.index == REG_THRESHOLD) threshold = mon_cfg.data[31:0];
        else if (mon_cfg.index < REG_THRESHOLD) coef_pair[mon_cfg.index] = mon_cfg.data;
      end
      if (mon_in.valid && mon_in.ready) begin
        want.query_index = mon_in.query_index;
        want.match_index = mon_in.match_index;
        want.deviation   = point_deviation(mon_in.model_x, mon_in.model_y, mon_in.model_z,
                                           mon_in.scene_x, mon_in.scene_y, mon_in.scene_z);
        want.is_inlier   = (want.deviation <= threshold);
        expected_results.insert(expected_results.size(), want);
      end
      if (mon_out.valid && mon_out.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual dev %h", $time,
                   mon_out.deviation);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (mon_out.out_query_index !== want.query_index) begin
            $display("%0t: query index expected %h actual %h", $time, want.query_index,
                     mon_out.out_query_index);
            fail_count++;
          end
          if (mon_out.out_match_index !== want.match_index) begin
            $display("%0t: match index expected %h actual %h", $time, want.match_index,
                     mon_out.out_match_index);
            fail_count++;
          end
          if (mon_out.deviation !== want.deviation) begin
            $display("%0t: deviation expected %h actual %h", $time, want.deviation,
                     mon_out.deviation);
            fail_count++;
          end
          if (mon_out.is_inlier !== want.is_inlier) begin
            $display("%0t: inlier flag expected %b actual %b", $time, want.is_inlier,
                     mon_out.is_inlier);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

/* tb/sv/correspondence_deviation_check_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// correspondence_deviation_check_core_tb
// Drives correspondences through the deviation check under several matrix
// and threshold settings, with bursty input and a stalling receiver.
// Checking is done by cdc_result_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module correspondence_deviation_check_core_tb;
  import cdc_pkg::*;

  localparam int IdleLimit  = 5000;
  localparam int DrainWait  = 30;
  localparam int LongHold   = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   burst_left = 0;
  int   hold_requests = 0;
  int   idle_cycles = 0;

  cdc_in_if  in_c ();
  cdc_out_if out_c ();
  cdc_cfg_if cfg_c ();

  correspondence_deviation_check_core dut (
    .clk(clk), .rst_n(rst_n), .in(in_c), .out(out_c), .cfg(cfg_c)
  );

  cdc_result_checker checker_i (
    .clk(clk), .rst_n(rst_n), .mon_in(in_c), .mon_out(out_c), .mon_cfg(cfg_c),
    .fail_count(fail_count), .pending(pending)
  );

  always #10 clk = ~clk;

  // Receiver: alternates between always ready and random stalls, and
  // honours requests for one long hold-off.
  always @(posedge clk) begin
    static int mode = 0, mode_left = 0, hold_left = 0, holds_seen = 0;
    if (hold_requests != holds_seen) begin
      holds_seen = hold_requests;
      hold_left  = LongHold;
    end
    if (mode_left == 0) begin
      mode      = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_c.ready <= 1'b0;
    end else if (mode == 0) begin
      out_c.ready <= 1'b1;
    end else begin
      out_c.ready <= ($urandom_range(0, 99) < (mode == 1 ? 70 : 25));
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk) begin
    if ((in_c.valid && in_c.ready) || (out_c.valid && out_c.ready) ||
        (cfg_c.valid && cfg_c.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Random coordinate: full range, small values or extremes.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      4:    return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000;
    endcase
  endfunction

  // Register write; valid is left high so back-to-back writes stay clean.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [63:0] val);
    cfg_c.valid <= 1'b1;
    cfg_c.index <= idx;
    cfg_c.data  <= val;
    do @(posedge clk); while (!cfg_c.ready);
  endtask

  // One correspondence beat, sometimes preceded by a gap when a burst runs out.
  task automatic send_item(input index_t qi, input index_t mi,
                           input coord_t mx, input coord_t my, input coord_t mz,
                           input coord_t sx, input coord_t sy, input coord_t sz);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_c.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_c.valid       <= 1'b1;
    in_c.query_index <= qi;
    in_c.match_index <= mi;
    in_c.model_x <= mx;
    in_c.model_y <= my;
    in_c.model_z <= mz;
    in_c.scene_x <= sx;
    in_c.scene_y <= sy;
    in_c.scene_z <= sz;
    do @(posedge clk); while (!in_c.ready);
  endtask

  task automatic wait_idle();
    in_c.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Matrix and threshold for one phase, extremes among them.
  task automatic program_phase(input int phase);
    logic [63:0] val;
    logic [31:0] thr;
    for (int r = 0; r < 6; r++) begin
      case (phase)
        1: val = 64'h7FFF_FFFF_7FFF_FFFF;
        2: val = 64'h8000_0000_8000_0000;
        3: val = {$urandom, $urandom};
        4: val = {32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000),
                  32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000)};
        default: val = {$urandom, $urandom};
      endcase
      write_reg(cfg_reg_t'(r), val);
    end
    case (phase)
      1: thr = 32'hFFFF_FFFF;
      2: thr = 32'h0000_0000;
      4: thr = $urandom_range(0, 32'h0004_0000);
      default: thr = $urandom;
    endcase
    write_reg(REG_THRESHOLD, {$urandom, thr});
    // An index past the register file must be ignored.
    write_reg(3'd7, {$urandom, $urandom});
    cfg_c.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    coord_t mx, my, mz;
    in_c.valid = 1'b0; in_c.query_index = 0; in_c.match_index = 0;
    in_c.model_x = 0; in_c.model_y = 0; in_c.model_z = 0;
    in_c.scene_x = 0; in_c.scene_y = 0; in_c.scene_z = 0;
    out_c.ready = 1'b0;
    cfg_c.valid = 1'b0; cfg_c.index = 0; cfg_c.data = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset matrix and threshold.
    send_item(16'h0000, 16'hFFFF, 0, 0, 0, 0, 0, 0);
    send_item(16'hFFFF, 16'h0000, 0, 0, 0, 32'sh0001_0000, 0, 0);
    send_item(16'h1234, 16'h5678, 0, 0, 0, 32'sh0001_0001, 0, 0);
    send_item(16'hAAAA, 16'h5555, 0, 0, 0, 0, 32'sh0000_FFFF, 0);
    send_item(16'h5555, 16'hAAAA, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_item(16'h0001, 16'h0002, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(16'h0003, 16'h0004, 32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0);
    send_item(16'h0005, 16'h0006, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(16'h0007, 16'h0008, -32'sd1, -32'sd1, -32'sd1, 0, 0, 0);
    send_item(16'h0009, 16'h000A, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0);
    wait_idle();

    // Writes of a scaled matrix and a new threshold, then directed beats
    // under it, so that floored negative products show up.
    write_reg(REG_ROW0_FIRST, 64'h0000_0000_0000_8000);
    write_reg(REG_ROW0_LAST,  64'hFFFF_0000_0000_0000);
    write_reg(REG_ROW1_FIRST, 64'h0000_8000_0000_0000);
    write_reg(REG_ROW1_LAST,  64'h0001_0000_0000_0000);
    write_reg(REG_ROW2_FIRST, 64'h0000_0000_0000_0000);
    write_reg(REG_ROW2_LAST,  64'h0000_0000_FFFF_8000);
    write_reg(REG_THRESHOLD,  64'h0000_0000_0002_0000);
    cfg_c.valid <= 1'b0;
    @(posedge clk);
    send_item(16'h0101, 16'h0202, -32'sd1, -32'sd3, 32'sd5, 0, 0, 0);
    send_item(16'h0303, 16'h0404, 32'sd1, 32'sd3, -32'sd5, 32'sh7FFF_FFFF, 0, 0);
    send_item(16'h0505, 16'h0606, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000,
              0, 32'sh0002_0000, 32'sh8000_0000);
    send_item(16'h0707, 16'h0808, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    wait_idle();

    // Random phases: each reprograms the block, then streams beats.
    for (int phase = 0; phase < 6; phase++) begin
      program_phase(phase);
      if (phase == 3) hold_requests++;
      for (int n = 0; n < 305; n++) begin
        mx = rand_coord();
        my = rand_coord();
        mz = rand_coord();
        if ($urandom_range(0, 3) != 0)
          // Scene close to the model point, so small deviations occur.
          send_item(index_t'($urandom), index_t'($urandom), mx, my, mz,
                    mx + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                    my + $signed($urandom_range(0, 255)) - 32'sd128,
                    mz + $signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000);
        else
          send_item(index_t'($urandom), index_t'($urandom), mx, my, mz, rand_coord(),
                    rand_coord(), rand_coord());
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* correspondence_deviation_check_core.f */
sv/cdc_pkg.sv
sv/cdc_in_if.sv
sv/cdc_out_if.sv
sv/cdc_cfg_if.sv
sv/cdc_cfg_regs.sv
sv/cdc_transform.sv
sv/cdc_isqrt.sv
sv/correspondence_deviation_check_core.sv
tb/sv/cdc_result_checker.sv
tb/sv/correspondence_deviation_check_core_tb.sv
